// ===== rtl/lpa_pkg.sv =====
// Shared types and constants for the loop period averager.
package lpa_pkg;

  localparam logic [31:0] INTERVAL_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] RATE_NUM     = 32'd4096000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV_MEAN,
    ST_MEAN_CHK,
    ST_DIV_RATE,
    ST_RATE_FIN,
    ST_DONE
  } lpa_state_t;

endpackage

// ===== rtl/loop_period_averager.sv =====
// Loop period averager: moving average of loop intervals and loop rate.
//
// Input channel (in_valid, in_stall, in_now_us) takes one loop-end timestamp
// in microseconds per transaction. The interval to the previous timestamp,
// saturated to 32 bits (zero for the first event), replaces the oldest entry
// of a ring of SAMPLES intervals held in a synchronous memory.
// Result channel (out_valid, out_stall) gives one transaction per input:
// the truncated mean of the ring, the rate 1000000/mean in UQ20.12 and a
// flag set when the mean is zero (rate then all ones).
// After acceptance the event passes through ST_READ, the mean division over
// the M bytes of the 32 + log2(SAMPLES) bit ring total, ST_MEAN_CHK, the
// rate division and ST_RATE_FIN; the last two are skipped when the mean is zero.
// The mean takes one byte per cycle by reciprocal multiplication; a radix-2
// restoring divider, one quotient bit per cycle, computes the rate.
// One event is processed at a time: the next transaction is accepted in the
// cycle after the result is registered.
// An output register holds the result while out_stall is high; the block
// finishes the next event meanwhile and holds it until the register frees.
// Reset (rst_n low, synchronous) clears the ring through per-entry valid
// bits, the time base and the write slot; no clearing pass is needed.
module loop_period_averager
  import lpa_pkg::*;
#(
  parameter int SAMPLES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_now_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_mean_interval_us,
  output logic [31:0] out_rate_per_second,
  output logic        out_rate_undefined
);

  localparam int SW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int TW = 32 + $clog2(SAMPLES);
  localparam int MD = (TW + 7) / 8;
  localparam int NW = 8 * MD;
  localparam int XW = SW + 8;
  localparam int RW = XW + 1;
  localparam int PW = XW + RW;
  localparam int MS = XW + $clog2(SAMPLES);
  localparam int QW = 32;
  localparam int CW = $clog2(QW + 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SAMPLES - 1);
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << MS) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  lpa_state_t state_r, state_nxt;

  logic          in_acc;
  logic          ring_we;
  logic          load_out;

  logic [63:0]   prev_time_r;
  logic          seen_first_r;
  logic [31:0]   interval_r;
  logic [SW-1:0] slot_r;
  logic [TW-1:0] total_r;
  logic [SAMPLES-1:0] vld_r;

  logic [31:0]   ring [SAMPLES];
  logic [31:0]   rd_data_r;
  logic          rd_vld_r;

  logic [NW-1:0] num_r;
  logic [SW-1:0] mrem_r;
  logic [32:0]   rem_r;
  logic [31:0]   den_r;
  logic [CW-1:0] cnt_r;

  logic [31:0]   res_mean_r;
  logic [31:0]   res_rate_r;
  logic          res_undef_r;

  logic          out_valid_r;
  logic [31:0]   out_mean_r;
  logic [31:0]   out_rate_r;
  logic          out_undef_r;

  logic [63:0]   delta;
  logic [31:0]   interval_nxt;
  logic [31:0]   old_val;
  logic [TW-1:0] total_nxt;
  logic [XW-1:0] mx;
  logic [7:0]    mq;
  logic [SW-1:0] mrem_nxt;
  logic [32:0]   rem_shift;
  logic          q_bit;
  logic [32:0]   rem_step;

  assign delta        = seen_first_r ? (in_now_us - prev_time_r) : 64'd0;
  assign interval_nxt = (delta[63:32] != 32'd0) ? INTERVAL_MAX : delta[31:0];
  assign old_val      = rd_vld_r ? rd_data_r : 32'd0;
  assign total_nxt    = total_r - TW'(old_val) + TW'(interval_r);

  assign mx       = {mrem_r, num_r[NW-1 -: 8]};
  assign mq       = 8'((PW'(mx) * PW'(RECIP)) >> MS);
  assign mrem_nxt = SW'(mx - XW'(mq) * XW'(SAMPLES));

  assign rem_shift = {rem_r[31:0], num_r[31]};
  assign q_bit     = (rem_shift >= {1'b0, den_r});
  assign rem_step  = q_bit ? (rem_shift - {1'b0, den_r}) : rem_shift;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_READ;
      ST_READ:     state_nxt = ST_DIV_MEAN;
      ST_DIV_MEAN: if (cnt_r == CW'(1)) state_nxt = ST_MEAN_CHK;
      ST_MEAN_CHK: state_nxt = (num_r[31:0] == 32'd0) ? ST_DONE : ST_DIV_RATE;
      ST_DIV_RATE: if (cnt_r == CW'(1)) state_nxt = ST_RATE_FIN;
      ST_RATE_FIN: state_nxt = ST_DONE;
      ST_DONE:     if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    ring_we  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: ring_we  = 1'b1;
      ST_DONE: load_out = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ring memory: registered read at acceptance, write back of the new interval
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= ring[slot_r];
    end
    if (ring_we) begin
      ring[slot_r] <= interval_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r  <= 64'd0;
      seen_first_r <= 1'b0;
      slot_r       <= '0;
      total_r      <= '0;
      vld_r        <= '0;
      rd_vld_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        prev_time_r  <= in_now_us;
        seen_first_r <= 1'b1;
        rd_vld_r     <= vld_r[slot_r];
      end
      if (ring_we) begin
        vld_r[slot_r] <= 1'b1;
        total_r       <= total_nxt;
        slot_r        <= (slot_r == SLOT_LAST) ? '0 : slot_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      interval_r <= interval_nxt;
    end
    unique case (state_r)
      ST_READ: begin
        num_r  <= NW'(total_nxt);
        mrem_r <= '0;
        cnt_r  <= CW'(MD);
      end
      ST_DIV_MEAN: begin
        num_r  <= {num_r[NW-9:0], mq};
        mrem_r <= mrem_nxt;
        cnt_r  <= cnt_r - CW'(1);
      end
      ST_MEAN_CHK: begin
        res_mean_r  <= num_r[31:0];
        den_r       <= num_r[31:0];
        num_r       <= NW'(RATE_NUM);
        rem_r       <= '0;
        cnt_r       <= CW'(QW);
        res_rate_r  <= INTERVAL_MAX;
        res_undef_r <= (num_r[31:0] == 32'd0);
      end
      ST_DIV_RATE: begin
        num_r <= NW'({num_r[30:0], q_bit});
        rem_r <= rem_step;
        cnt_r <= cnt_r - CW'(1);
      end
      ST_RATE_FIN: res_rate_r <= num_r[31:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mean_r  <= res_mean_r;
      out_rate_r  <= res_rate_r;
      out_undef_r <= res_undef_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_mean_interval_us = out_mean_r;
  assign out_rate_per_second  = out_rate_r;
  assign out_rate_undefined   = out_undef_r;

endmodule
